// ----- rtl/asss_pkg.sv -----
`default_nettype none
package asss_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_SORT  = 3'd3,
    CMD_GTT   = 3'd4,
    CMD_LUP   = 3'd5,
    CMD_LDOWN = 3'd6,
    CMD_NOP   = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    DOP_NONE   = 3'd0,
    DOP_WRITE  = 3'd1,
    DOP_RDI    = 3'd2,
    DOP_RDJ    = 3'd3,
    DOP_WRI    = 3'd4,
    DOP_WRJ    = 3'd5,
    DOP_RDTOP  = 3'd6
  } dop_t;

  // controller -> datapath
  typedef struct packed {
    dop_t        op;
    logic [5:0]  addr;
    logic [31:0] wdata;
    logic        hold_top;
    logic        cnt_inc;
    logic        cnt_dec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] wi;
    logic [31:0] wj;
    logic [31:0] top;
    logic [6:0]  count;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/asss_datapath.sv -----
`default_nettype none
module asss_datapath #(
  parameter int DEPTH = 64
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  asss_pkg::dp_cmd_t     cmd,
  output asss_pkg::dp_sts_t     sts
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r, wi_r, wj_r, top_r;
  logic [6:0]  count_r;
  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] a;

  assign a = cmd.addr[$bits(a)-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      asss_pkg::DOP_WRITE: mem[a] <= cmd.wdata;
      asss_pkg::DOP_WRI:   mem[a] <= cmd.wdata;
      asss_pkg::DOP_WRJ:   mem[a] <= cmd.wdata;
      default: ;
    endcase
    rdata_r <= mem[a];
    if (cmd.op == asss_pkg::DOP_RDI) wi_r <= mem[a];
    if (cmd.op == asss_pkg::DOP_RDJ) wj_r <= mem[a];
    if (cmd.op == asss_pkg::DOP_WRI) wi_r <= cmd.wdata;
    // swap: keep the old i word for the write back into j
    if (cmd.op == asss_pkg::DOP_WRI) wj_r <= wi_r;
    if (cmd.hold_top) top_r <= rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + 7'd1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 7'd1;
    end
  end

  assign sts.rdata = rdata_r;
  assign sts.wi    = wi_r;
  assign sts.wj    = wj_r;
  assign sts.top   = top_r;
  assign sts.count = count_r;
endmodule
`default_nettype wire

// ----- rtl/asss_ctrl.sv -----
`default_nettype none
module asss_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         in_command,
  input  wire  signed [31:0] in_value,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_top_marker,
  output logic [6:0]         out_entry_count,
  output logic               out_empty_flag,
  output logic               out_full_flag,
  output logic               out_last,
  output asss_pkg::dp_cmd_t  dcmd,
  input  asss_pkg::dp_sts_t  dsts
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EMIT, S_SI, S_SJ, S_SCMP, S_SWJ, S_GTOP, S_GRD, S_GCHK, S_GFIN, S_WAIT
  } state_t;

  state_t      state_r;
  logic [2:0]  cmd_r;
  logic [6:0]  i_r, j_r, cnt;
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  ostatus_r;
  logic [31:0] odata_r;
  logic        omark_r, olast_r;
  logic [31:0] pdata_r;
  logic        pmark_r;
  logic        free;
  logic [6:0]  dmax;

  assign dmax = 7'(DEPTH);
  assign cnt  = dsts.count;
  assign free = !ovalid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !free;

  assign out_valid       = ovalid_r;
  assign out_status      = ostatus_r;
  assign out_data        = odata_r;
  assign out_top_marker  = omark_r;
  assign out_last        = olast_r;
  assign out_entry_count = cnt;
  assign out_empty_flag  = (cnt == 7'd0);
  assign out_full_flag   = (cnt == dmax);

  // datapath commands from present state and, in S_IDLE, the input command
  always_comb begin
    dcmd = '0;
    dcmd.op = asss_pkg::DOP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid && free) begin
          case (in_command)
            asss_pkg::CMD_PUSH: if (cnt < dmax) begin
              dcmd.op = asss_pkg::DOP_WRITE;
              dcmd.addr = cnt[5:0];
              dcmd.wdata = in_value;
              dcmd.cnt_inc = 1'b1;
            end
            asss_pkg::CMD_POP, asss_pkg::CMD_PEEK, asss_pkg::CMD_GTT: begin
              dcmd.addr = 6'(cnt - 7'd1);
              dcmd.cnt_dec = (in_command == asss_pkg::CMD_POP) && (cnt != 7'd0);
            end
            default: ;
          endcase
        end
      end
      // hold the read address while a result waits
      S_RD, S_EMIT, S_GCHK: dcmd.addr = i_r[5:0];
      S_GRD: dcmd.addr = 6'(i_r - 7'd1);
      S_SI: begin dcmd.op = asss_pkg::DOP_RDI; dcmd.addr = i_r[5:0]; end
      S_SJ: begin dcmd.op = asss_pkg::DOP_RDJ; dcmd.addr = j_r[5:0]; end
      S_SCMP: if ($signed(dsts.wi) > $signed(dsts.wj)) begin
        dcmd.op = asss_pkg::DOP_WRI; dcmd.addr = i_r[5:0]; dcmd.wdata = dsts.wj;
      end
      S_SWJ: begin dcmd.op = asss_pkg::DOP_WRJ; dcmd.addr = j_r[5:0]; dcmd.wdata = dsts.wj; end
      S_GTOP: dcmd.hold_top = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r && out_stall;
    case (state_r)
      S_IDLE: if (in_valid && free &&
                  (in_command inside {asss_pkg::CMD_PUSH, asss_pkg::CMD_NOP} ||
                   cnt == 7'd0)) begin
        ovalid_nxt = 1'b1;
      end
      S_WAIT: ovalid_nxt = 1'b1;
      S_EMIT, S_GFIN: if (free) ovalid_nxt = 1'b1;
      S_GCHK: if (free && $signed(dsts.rdata) > $signed(dsts.top)) ovalid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      case (state_r)
        S_IDLE: if (in_valid && free) begin
          cmd_r <= in_command;
          odata_r <= '0;
          omark_r <= 1'b0;
          olast_r <= 1'b1;
          if (in_command == asss_pkg::CMD_PUSH || in_command == asss_pkg::CMD_NOP) begin
            ostatus_r <= (in_command == asss_pkg::CMD_PUSH && cnt >= dmax) ?
                         asss_pkg::ST_OVF : asss_pkg::ST_OK;
          end else if (cnt == 7'd0) begin
            ostatus_r <= asss_pkg::ST_EMPTY;
          end else begin
            ostatus_r <= asss_pkg::ST_OK;
            case (in_command)
              asss_pkg::CMD_POP, asss_pkg::CMD_PEEK: state_r <= S_WAIT;
              asss_pkg::CMD_GTT: state_r <= S_GTOP;
              asss_pkg::CMD_SORT: begin i_r <= '0; j_r <= 7'd1; state_r <= S_SI; end
              asss_pkg::CMD_LUP: begin i_r <= '0; state_r <= S_RD; end
              default: begin i_r <= cnt - 7'd1; state_r <= S_RD; end
            endcase
          end
        end
        S_WAIT: begin
          odata_r <= dsts.rdata;
          state_r <= S_IDLE;
        end
        // list: address issued in S_RD, data emitted in S_EMIT
        S_RD: state_r <= S_EMIT;
        S_EMIT: if (free) begin
          odata_r <= dsts.rdata;
          if (cmd_r == asss_pkg::CMD_LDOWN) begin
            olast_r <= (i_r == 7'd0);
            state_r <= (i_r == 7'd0) ? S_IDLE : S_RD;
            i_r <= i_r - 7'd1;
          end else begin
            olast_r <= (i_r == cnt - 7'd1);
            state_r <= (i_r == cnt - 7'd1) ? S_IDLE : S_RD;
            i_r <= i_r + 7'd1;
          end
        end
        S_SI: state_r <= (j_r >= cnt) ? S_RD : S_SJ;
        S_SJ: state_r <= S_SCMP;
        // swap writes wj into i now and old wi into j next cycle
        S_SCMP: state_r <= S_SWJ;
        S_SWJ: begin
          if (j_r + 7'd1 < cnt) begin
            j_r <= j_r + 7'd1;
            state_r <= S_SJ;
          end else if (i_r + 7'd2 < cnt) begin
            i_r <= i_r + 7'd1;
            j_r <= i_r + 7'd2;
            state_r <= S_SI;
          end else begin
            i_r <= '0;
            state_r <= S_RD;
          end
        end
        // greater-than-top: keep one word pending so the final one carries last
        S_GTOP: begin
          pdata_r <= dsts.rdata;
          pmark_r <= 1'b1;
          i_r <= cnt - 7'd1;
          state_r <= (cnt == 7'd1) ? S_GFIN : S_GRD;
        end
        S_GRD: begin
          i_r <= i_r - 7'd1;
          state_r <= S_GCHK;
        end
        S_GCHK: if (free) begin
          if ($signed(dsts.rdata) > $signed(dsts.top)) begin
            odata_r <= pdata_r;
            omark_r <= pmark_r;
            olast_r <= 1'b0;
            pdata_r <= dsts.rdata;
            pmark_r <= 1'b0;
          end
          state_r <= (i_r == 7'd0) ? S_GFIN : S_GRD;
        end
        S_GFIN: if (free) begin
          odata_r <= pdata_r;
          omark_r <= pmark_r;
          olast_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/array_stack_with_sort_and_scan_unit.sv -----
// channel | ports                                   | transfer when
// input   | in_valid, in_stall, in_command, in_value | in_valid && !in_stall
// output  | out_valid, out_stall, out_* fields      | out_valid && !out_stall
// Push, unused codes, empty-stack results: from S_IDLE; pop and peek: via S_WAIT.
// List: S_RD and S_EMIT per word; sort: S_SJ, S_SCMP, S_SWJ per pair, S_SI per pass.
// Greater-than-top: S_GTOP, then S_GRD and S_GCHK per word below top, then S_GFIN.
// Reset: synchronous rst_n clears the count; store contents stay undefined.
// Output stall holds the result register and pauses the walk.
`default_nettype none
module array_stack_with_sort_and_scan_unit #(
  parameter int DEPTH = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         in_command,
  input  wire  signed [31:0] in_value,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_top_marker,
  output logic [6:0]         out_entry_count,
  output logic               out_empty_flag,
  output logic               out_full_flag,
  output logic               out_last
);
  asss_pkg::dp_cmd_t dcmd;
  asss_pkg::dp_sts_t dsts;

  asss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_value,
    .out_valid, .out_stall, .out_status, .out_data, .out_top_marker,
    .out_entry_count, .out_empty_flag, .out_full_flag, .out_last,
    .dcmd, .dsts
  );

  asss_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst_n, .cmd(dcmd), .sts(dsts)
  );
endmodule
`default_nettype wire

// ----- rtl/asss_checker.sv -----
`default_nettype none
module asss_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_status,
  input wire [31:0] out_data,
  input wire        out_empty_flag,
  input wire        out_last,
  input wire        out_top_marker
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input open while a result waits");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != asss_pkg::ST_OK |-> out_last && out_data == 32'd0)
    else $error("error result not single");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == asss_pkg::ST_EMPTY |-> out_empty_flag)
    else $error("empty status without empty flag");
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_top_marker |-> out_status == asss_pkg::ST_OK)
    else $error("marker on error");
endmodule

bind array_stack_with_sort_and_scan_unit asss_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_status,
  .out_data, .out_empty_flag, .out_last, .out_top_marker
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH = 64;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] data;
    logic        top_marker;
    logic [6:0]  entry_count;
    logic        empty_flag;
    logic        full_flag;
    logic        last;
  } stack_result_t;

  class stack_scoreboard;
    logic [31:0] words[DEPTH];
    int unsigned depth_now;
    stack_result_t pending[$];
    int errors;

    function new();
      depth_now = 0;
      errors = 0;
    endfunction

    function void add_result(logic [1:0] st, logic [31:0] d, logic mk);
      stack_result_t r;
      r.status = st;
      r.data = d;
      r.top_marker = mk;
      r.entry_count = depth_now[6:0];
      r.empty_flag = (depth_now == 0);
      r.full_flag = (depth_now == DEPTH);
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    // Predict every result caused by one accepted command.
    function void note_command(logic [2:0] cmd, logic [31:0] val);
      int unsigned n;
      logic [31:0] t;
      n = depth_now;
      if (cmd == asss_pkg::CMD_PUSH) begin
        if (n >= DEPTH) begin
          add_result(asss_pkg::ST_OVF, '0, 1'b0);
        end else begin
          words[n] = val;
          depth_now = n + 1;
          add_result(asss_pkg::ST_OK, '0, 1'b0);
        end
      end else if (cmd == asss_pkg::CMD_NOP) begin
        add_result(asss_pkg::ST_OK, '0, 1'b0);
      end else if (n == 0) begin
        add_result(asss_pkg::ST_EMPTY, '0, 1'b0);
      end else if (cmd == asss_pkg::CMD_POP) begin
        depth_now = n - 1;
        add_result(asss_pkg::ST_OK, words[n-1], 1'b0);
      end else if (cmd == asss_pkg::CMD_PEEK) begin
        add_result(asss_pkg::ST_OK, words[n-1], 1'b0);
      end else if (cmd == asss_pkg::CMD_SORT || cmd == asss_pkg::CMD_LUP) begin
        if (cmd == asss_pkg::CMD_SORT) begin
          for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
              if ($signed(words[i]) > $signed(words[j])) begin
                t = words[i];
                words[i] = words[j];
                words[j] = t;
              end
        end
        for (int i = 0; i < n; i++) add_result(asss_pkg::ST_OK, words[i], 1'b0);
      end else if (cmd == asss_pkg::CMD_GTT) begin
        t = words[n-1];
        add_result(asss_pkg::ST_OK, t, 1'b1);
        for (int i = n - 1; i > 0; i--)
          if ($signed(words[i-1]) > $signed(t))
            add_result(asss_pkg::ST_OK, words[i-1], 1'b0);
      end else begin
        for (int i = n; i > 0; i--) add_result(asss_pkg::ST_OK, words[i-1], 1'b0);
      end
      pending[$].last = 1'b1;
    endfunction

    function void check_result(stack_result_t act);
      stack_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: data %h", act.data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, act.status); errors++;
      end
      if (act.data !== e.data) begin
        $error("data: expected %h, actual %h", e.data, act.data); errors++;
      end
      if (act.top_marker !== e.top_marker) begin
        $error("top_marker: expected %b, actual %b", e.top_marker, act.top_marker);
        errors++;
      end
      if (act.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, act.entry_count);
        errors++;
      end
      if (act.empty_flag !== e.empty_flag) begin
        $error("empty_flag: expected %b, actual %b", e.empty_flag, act.empty_flag);
        errors++;
      end
      if (act.full_flag !== e.full_flag) begin
        $error("full_flag: expected %b, actual %b", e.full_flag, act.full_flag);
        errors++;
      end
      if (act.last !== e.last) begin
        $error("last: expected %b, actual %b", e.last, act.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_data;
  logic out_top_marker;
  logic [6:0] out_entry_count;
  logic out_empty_flag, out_full_flag, out_last;

  stack_scoreboard sb = new();
  bit calm = 1'b0;        // no idling on either side
  int hold_reqs = 0;      // bumped by the sender to ask for a long hold-off
  int holds_seen = 0;
  int hold_left = 0;      // receiver holds off this many more cycles

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  array_stack_with_sort_and_scan_unit #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_data(out_data),
    .out_top_marker(out_top_marker), .out_entry_count(out_entry_count),
    .out_empty_flag(out_empty_flag), .out_full_flag(out_full_flag),
    .out_last(out_last)
  );

  // Check every result transfer at the rising edge.
  always @(posedge clk) begin
    stack_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.status = out_status;
      r.data = out_data;
      r.top_marker = out_top_marker;
      r.entry_count = out_entry_count;
      r.empty_flag = out_empty_flag;
      r.full_flag = out_full_flag;
      r.last = out_last;
      sb.check_result(r);
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (holds_seen != hold_reqs) begin
      holds_seen <= hold_reqs;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 23);
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [31:0] val);
    if (!calm) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(cmd, val);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      3: return -$urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_command(int unsigned n);
    int unsigned p;
    p = $urandom_range(99);
    if (n < 8 && p < 60) return asss_pkg::CMD_PUSH;
    if (p < 40) return asss_pkg::CMD_PUSH;
    if (p < 55) return asss_pkg::CMD_POP;
    if (p < 65) return asss_pkg::CMD_PEEK;
    if (p < 72) return asss_pkg::CMD_SORT;
    if (p < 82) return asss_pkg::CMD_GTT;
    if (p < 89) return asss_pkg::CMD_LUP;
    if (p < 96) return asss_pkg::CMD_LDOWN;
    return asss_pkg::CMD_NOP;
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty cases, extremes, every command.
    send_command(asss_pkg::CMD_POP, '0);
    send_command(asss_pkg::CMD_PEEK, '0);
    send_command(asss_pkg::CMD_SORT, '0);
    send_command(asss_pkg::CMD_GTT, '0);
    send_command(asss_pkg::CMD_LUP, '0);
    send_command(asss_pkg::CMD_LDOWN, '0);
    send_command(asss_pkg::CMD_NOP, 32'hffff_ffff);
    send_command(asss_pkg::CMD_PUSH, 32'h7fff_ffff);
    send_command(asss_pkg::CMD_GTT, '0);
    send_command(asss_pkg::CMD_PUSH, 32'h8000_0000);
    send_command(asss_pkg::CMD_PUSH, 32'hffff_ffff);
    send_command(asss_pkg::CMD_PUSH, 32'h0000_0000);
    send_command(asss_pkg::CMD_PEEK, '0);
    send_command(asss_pkg::CMD_GTT, '0);
    send_command(asss_pkg::CMD_LUP, '0);
    send_command(asss_pkg::CMD_LDOWN, '0);
    send_command(asss_pkg::CMD_SORT, '0);
    send_command(asss_pkg::CMD_POP, '0);
    send_command(asss_pkg::CMD_POP, '0);

    // Fill to full with no idling, then overflow and walk a full stack.
    calm = 1'b1;
    while (sb.depth_now < DEPTH) send_command(asss_pkg::CMD_PUSH, $urandom);
    send_command(asss_pkg::CMD_PUSH, 32'h5555_aaaa);
    send_command(asss_pkg::CMD_GTT, '0);
    calm = 1'b0;
    // Long receiver hold-off while the sender keeps offering.
    drop_valid();
    hold_reqs = hold_reqs + 1;
    send_command(asss_pkg::CMD_LDOWN, '0);
    send_command(asss_pkg::CMD_SORT, '0);
    send_command(asss_pkg::CMD_PEEK, '0);
    send_command(asss_pkg::CMD_GTT, '0);
    wait_drained();
    while (sb.depth_now > 0) send_command(asss_pkg::CMD_POP, '0);
    send_command(asss_pkg::CMD_POP, '0);

    // Random part, mostly small stacks.
    for (int k = 0; k < 300; k++) begin
      logic [2:0] c;
      if (k == 120) calm = 1'b1;
      if (k == 180) calm = 1'b0;
      if (k == 240) wait_drained();
      c = pick_command(sb.depth_now);
      if (sb.depth_now > 16 && c == asss_pkg::CMD_PUSH && $urandom_range(1))
        c = asss_pkg::CMD_POP;
      send_command(c, pick_word());
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("** array_stack_with_sort_and_scan_unit: PASSED **");
    end else begin
      $display("** array_stack_with_sort_and_scan_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("** array_stack_with_sort_and_scan_unit: FAILED **");
    $finish;
  end
endmodule
